FILE: hw/rtl/sarv_pkg.sv
// ----------------------------------------------------------------------------
// sarv_pkg: shared types and constants for the sort-and-rank block
// Holds the sequencer state type, the control group for the rank unit and
// the fixed width of the rank field.
// ----------------------------------------------------------------------------
package sarv_pkg;

   localparam int RANK_BITS = 6;

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_FETCH,
      ST_LOAD,
      ST_SWEEP,
      ST_OUT
   } sarv_state_type;

   typedef struct packed {
      logic load;   // capture the value being ranked, clear the count
      logic step;   // compare the read entry and count it if smaller
   } sarv_rank_ctl_type;

endpackage

FILE: hw/rtl/sort_and_rank_values_top.sv
// ----------------------------------------------------------------------------
// sort_and_rank_values_top: rank each value of a set by ascending order
// Usage: send values on the req_ channel, one per transaction; the
// transaction with req_last high closes the set. While collecting, each
// transaction is met with req_ready high. After the closing transaction the
// block drops req_ready and returns one rsp_ transaction per stored value,
// in arrival order, with its rank (count of smaller values); rsp_last_out
// marks the final one. Up to DEPTH values are kept; further ones are
// dropped and rsp_overflow is high on every result of that set.
// Each result passes through fetch, load, a sweep of the store through
// the one shared comparator, and present.
// A stalled receiver holds the result in place; the sequencer waits.
// Reset: synchronous; the set is emptied and the block is ready to collect.
// ----------------------------------------------------------------------------
module sort_and_rank_values_top #(
   parameter int DEPTH      = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   // input values
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [VALUE_BITS-1:0]   req_value,
   input  logic                           req_last,
   // ranked results
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [VALUE_BITS-1:0]   rsp_value_out,
   output logic [sarv_pkg::RANK_BITS-1:0] rsp_rank,
   output logic                           rsp_overflow,
   output logic                           rsp_last_out
);
   import sarv_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   logic [VALUE_BITS-1:0] rd_data;
   sarv_rank_ctl_type     rank_ctl;

   // Value store: written in arrival order while collecting, read one
   // entry per cycle during each sweep.
   sarv_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer: owns item count, overflow flag and the fetch/sweep indexes.
   sarv_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_last     (req_last),
      .req_ready    (req_ready),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .rd_addr      (rd_addr),
      .rank_ctl     (rank_ctl),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_overflow (rsp_overflow),
      .rsp_last_out (rsp_last_out)
   );

   // Shared comparator: its registers also hold the result payload steady
   // while the receiver stalls.
   sarv_rank #(
      .VALUE_BITS (VALUE_BITS),
      .DEPTH      (DEPTH)
   ) u_rank (
      .clock     (clock),
      .ctl       (rank_ctl),
      .rd_data   (rd_data),
      .value_out (rsp_value_out),
      .rank      (rsp_rank)
   );

endmodule

FILE: hw/rtl/sarv_ram.sv
// ----------------------------------------------------------------------------
// sarv_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module sarv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/sarv_rank.sv
// ----------------------------------------------------------------------------
// sarv_rank: shared comparator and rank counter
// Holds the value being ranked and counts stored entries below it, one
// entry per cycle as the sequencer sweeps the store.
// ----------------------------------------------------------------------------
module sarv_rank #(
   parameter int VALUE_BITS = 32,
   parameter int DEPTH      = 64
) (
   input  logic                               clock,
   input  sarv_pkg::sarv_rank_ctl_type        ctl,
   input  logic [VALUE_BITS-1:0]              rd_data,
   output logic signed [VALUE_BITS-1:0]       value_out,
   output logic [sarv_pkg::RANK_BITS-1:0]     rank
);
   import sarv_pkg::*;

   localparam int RW = $clog2(DEPTH);

   logic signed [VALUE_BITS-1:0] cur_ff;
   logic signed [VALUE_BITS-1:0] cur_in;
   logic [RW-1:0]                cnt_ff;
   logic [RW-1:0]                cnt_in;
   logic                         is_less;

   assign is_less = $signed(rd_data) < cur_ff;

   always_comb begin
      cur_in = cur_ff;
      cnt_in = cnt_ff;
      if (ctl.load) begin
         cur_in = $signed(rd_data);
         cnt_in = '0;
      end else if (ctl.step && is_less) begin
         cnt_in = RW'(cnt_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      cnt_ff <= cnt_in;
   end

   assign value_out = cur_ff;
   assign rank      = RANK_BITS'(cnt_ff);

endmodule

FILE: hw/rtl/sarv_ctrl.sv
// ----------------------------------------------------------------------------
// sarv_ctrl: sequencer for collection and ranking
// Collects values into the store, then for each stored entry fetches it,
// sweeps all entries past the shared comparator and presents the result.
// ----------------------------------------------------------------------------
module sarv_ctrl #(
   parameter int DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_last,
   output logic                        req_ready,
   output logic                        wr_en,
   output logic [$clog2(DEPTH)-1:0]    wr_addr,
   output logic [$clog2(DEPTH)-1:0]    rd_addr,
   output sarv_pkg::sarv_rank_ctl_type rank_ctl,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_overflow,
   output logic                        rsp_last_out
);
   import sarv_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   sarv_state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  sweep_ff, sweep_in;
   logic [AW-1:0]  idx_ff, idx_in;
   logic           ovf_ff, ovf_in;
   logic           accept;
   logic           has_room;
   logic           last_item;

   assign accept    = req_valid && req_ready;
   assign has_room  = count_ff < CW'(DEPTH);
   assign last_item = (CW'(idx_ff) + CW'(1)) == count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_COLLECT: if (req_valid && req_last) state_in = ST_FETCH;
         ST_FETCH:   state_in = ST_LOAD;
         ST_LOAD:    state_in = ST_SWEEP;
         ST_SWEEP:   if (sweep_ff == count_ff) state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = last_item ? ST_COLLECT : ST_FETCH;
            end
         end
         default:    state_in = ST_COLLECT;
      endcase
   end

   // counters
   always_comb begin
      count_in = count_ff;
      sweep_in = sweep_ff;
      idx_in   = idx_ff;
      ovf_in   = ovf_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (accept) begin
               if (has_room) begin
                  count_in = CW'(count_ff + 1'b1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         ST_LOAD:  sweep_in = CW'(1);
         ST_SWEEP: begin
            if (sweep_ff != count_ff) begin
               sweep_in = CW'(sweep_ff + 1'b1);
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (last_item) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  idx_in   = '0;
               end else begin
                  idx_in = AW'(idx_ff + 1'b1);
               end
            end
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      rank_ctl.load = 1'b0;
      rank_ctl.step = 1'b0;
      rd_addr       = '0;
      unique case (state_ff)
         ST_COLLECT: req_ready = 1'b1;
         ST_FETCH:   rd_addr = idx_ff;
         ST_LOAD:    rank_ctl.load = 1'b1;
         ST_SWEEP: begin
            rank_ctl.step = 1'b1;
            rd_addr       = sweep_ff[AW-1:0];
         end
         ST_OUT:     rsp_valid = 1'b1;
         default: ;
      endcase
   end

   assign wr_en        = accept && has_room;
   assign wr_addr      = count_ff[AW-1:0];
   assign rsp_overflow = ovf_ff;
   assign rsp_last_out = last_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         count_ff <= '0;
         sweep_ff <= '0;
         idx_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sweep_ff <= sweep_in;
         idx_ff   <= idx_in;
         ovf_ff   <= ovf_in;
      end
   end

`ifndef SYNTHESIS
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and result handshakes open together");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("item count beyond store depth");

   a_idx_in_set: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_COLLECT) |-> (CW'(idx_ff) < count_ff))
      else $error("ranked entry index outside the set");

   a_run_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_out) |=> (req_ready && count_ff == '0 && !ovf_ff))
      else $error("set not cleared after final result");
`endif

endmodule

FILE: sim/sort_and_rank_values_top_tb.sv
// ----------------------------------------------------------------------------
// sort_and_rank_values_top_tb: self-checking bench for the sort-and-rank block
// Sends sets of signed values on the req_ channel and checks every ranked
// result on the rsp_ channel against a rank computed here. Runs short
// directed sets first (single value, extremes, equal values, descending
// order), then a full store, an overflowing set, receiver and sender pauses,
// and random sets, with random idling on both channels.
// ----------------------------------------------------------------------------
module sort_and_rank_values_top_tb;

   import sarv_pkg::*;

   localparam int     DEPTH        = 64;
   localparam int     VALUE_BITS   = 32;
   localparam int     IDLE_PCT     = 34;
   localparam int     LONG_STALL   = 300;
   localparam int     RANDOM_ITEMS = 12;
   // tail after the final drain: room for two results of a full set
   localparam int     TAIL_CYCLES  = 2 * (DEPTH + 3);
   localparam longint TIMEOUT      = 64'd12 * 64'd400000;

   typedef logic signed [VALUE_BITS-1:0] value_type;

   typedef struct {
      value_type            value;
      logic [RANK_BITS-1:0] rank;
      logic                 overflow;
      logic                 last;
   } ranked_value_type;

   // clock, reset and the driven inputs, all known from time zero
   logic      clock     = 1'b0;
   logic      reset     = 1'b1;
   logic      req_valid = 1'b0;
   value_type req_value = '0;
   logic      req_last  = 1'b0;
   logic      rsp_ready = 1'b0;

   logic                 req_ready;
   logic                 rsp_valid;
   value_type            rsp_value_out;
   logic [RANK_BITS-1:0] rsp_rank;
   logic                 rsp_overflow;
   logic                 rsp_last_out;

   // copy of the set as the block should hold it
   value_type        set_store [DEPTH];
   int               set_count    = 0;
   logic             set_overflow = 1'b0;
   ranked_value_type pending_ranks [$];

   int   mismatches     = 0;
   logic steady         = 1'b0;   // high: neither side idles
   int   stall_requests = 0;      // bumped by a test to ask for a long hold-off
   int   stall_served   = 0;
   int   stall_left     = 0;

   sort_and_rank_values_top #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_out (rsp_value_out),
      .rsp_rank      (rsp_rank),
      .rsp_overflow  (rsp_overflow),
      .rsp_last_out  (rsp_last_out)
   );

   always #6 clock = ~clock;

   // Store one accepted value; on the closing one, rank every stored value
   // against all others and queue the results in arrival order.
   function automatic void rank_accepted(value_type v, logic closing);
      int               smaller;
      ranked_value_type r;
      if (set_count < DEPTH) begin
         set_store[set_count] = v;
         set_count++;
      end else begin
         // store full: drop the value, closing one included
         set_overflow = 1'b1;
      end
      if (closing) begin
         for (int i = 0; i < set_count; i++) begin
            smaller = 0;
            // equal values share a rank: count strictly smaller ones only
            for (int j = 0; j < set_count; j++) begin
               if (set_store[j] < set_store[i]) smaller++;
            end
            r.value    = set_store[i];
            r.rank     = RANK_BITS'(smaller);
            r.overflow = set_overflow;
            r.last     = (i == set_count - 1);
            pending_ranks.push_back(r);
         end
         set_count    = 0;
         set_overflow = 1'b0;
      end
   endfunction

   // Mix of full-range values, a small pool that repeats, and the extremes.
   function automatic value_type pick_value();
      value_type v;
      case ($urandom_range(9))
         6, 7: v = value_type'($urandom_range(0, 8)) - value_type'(4);
         8: begin
            case ($urandom_range(3))
               0: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
               1: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
               2: v = '0;
               default: v = '1;
            endcase
         end
         default: v = value_type'($urandom);
      endcase
      return v;
   endfunction

   // Offer one transaction and hold it until accepted; then maybe idle.
   task automatic send_value(value_type v, logic closing);
      req_valid <= 1'b1;
      req_value <= v;
      req_last  <= closing;
      do @(posedge clock); while (!req_ready);
      rank_accepted(v, closing);
      if (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // Drop valid and hold the sender until every queued result has come.
   task automatic wait_for_all_results();
      req_valid <= 1'b0;
      while (pending_ranks.size() != 0) @(posedge clock);
   endtask

   task automatic test_single_value();
      send_value({1'b1, {(VALUE_BITS-1){1'b0}}}, 1'b1);
      send_value({1'b0, {(VALUE_BITS-1){1'b1}}}, 1'b1);
   endtask

   task automatic test_extremes();
      send_value('0, 1'b0);
      send_value({1'b0, {(VALUE_BITS-1){1'b1}}}, 1'b0);
      send_value({1'b1, {(VALUE_BITS-1){1'b0}}}, 1'b0);
      send_value('1, 1'b0);
      send_value(value_type'(1), 1'b0);
      send_value({1'b1, {(VALUE_BITS-2){1'b0}}, 1'b1}, 1'b1);
   endtask

   task automatic test_equal_values();
      send_value(value_type'(5), 1'b0);
      send_value(-value_type'(3), 1'b0);
      send_value(value_type'(5), 1'b0);
      send_value(value_type'(5), 1'b0);
      send_value(-value_type'(3), 1'b1);
   endtask

   task automatic test_descending();
      for (int k = 0; k < 5; k++) send_value(value_type'(200 - 100 * k), k == 4);
   endtask

   // Fill every entry with both sides running flat out: ranks reach the top.
   task automatic test_full_store();
      steady = 1'b1;
      for (int k = 0; k < DEPTH; k++) send_value(value_type'($urandom), k == DEPTH - 1);
      wait_for_all_results();
      steady = 1'b0;
   endtask

   // Two extra values, the closing one among them, are dropped.
   task automatic test_overflow();
      for (int k = 0; k < DEPTH + 2; k++) send_value(pick_value(), k == DEPTH + 1);
   endtask

   // Hold the receiver off while two sets are offered: the block fills the
   // output and stalls its input until the hold-off ends.
   task automatic test_receiver_stall();
      stall_requests++;
      for (int s = 0; s < 2; s++) begin
         for (int k = 0; k < 6; k++) send_value(pick_value(), k == 5);
      end
   endtask

   // Pause the sender until the block has drained, then go on at once.
   task automatic test_sender_pause();
      for (int k = 0; k < 3; k++) send_value(pick_value(), k == 2);
      wait_for_all_results();
      for (int k = 0; k < 3; k++) send_value(pick_value(), k == 2);
   endtask

   // Mostly small sets, a few larger ones, with occasional drains between.
   task automatic test_random_sets();
      int sent;
      int set_len;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         set_len = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 24);
         if (set_len > RANDOM_ITEMS - sent) set_len = RANDOM_ITEMS - sent;
         for (int k = 0; k < set_len; k++) send_value(pick_value(), k == set_len - 1);
         sent += set_len;
         if ($urandom_range(99) < 20) wait_for_all_results();
      end
   endtask

   // Receiver: random ready, a long hold-off on request, none while steady.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_served != stall_requests) begin
         stall_served = stall_requests;
         stall_left   = LONG_STALL;
         rsp_ready   <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Checker: compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      ranked_value_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_ranks.size() == 0) begin
            $error("result transaction with no expectation: value_out %0d rank %0d",
                   rsp_value_out, rsp_rank);
            mismatches++;
         end else begin
            want = pending_ranks.pop_front();
            if (rsp_value_out !== want.value) begin
               $error("value_out: expected %0d, got %0d", want.value, rsp_value_out);
               mismatches++;
            end
            if (rsp_rank !== want.rank) begin
               $error("rank: expected %0d, got %0d", want.rank, rsp_rank);
               mismatches++;
            end
            if (rsp_overflow !== want.overflow) begin
               $error("overflow: expected %0b, got %0b", want.overflow, rsp_overflow);
               mismatches++;
            end
            if (rsp_last_out !== want.last) begin
               $error("last_out: expected %0b, got %0b", want.last, rsp_last_out);
               mismatches++;
            end
         end
      end
   end

   // Main sequence: reset once, run each test, drain, then report.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_value();
      test_extremes();
      test_equal_values();
      test_descending();
      test_full_store();
      test_overflow();
      test_receiver_stall();
      test_sender_pause();
      test_random_sets();
      wait_for_all_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_ranks.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog: end a hung run.
   initial begin
      #TIMEOUT;
      $display("FAIL");
      $finish;
   end

endmodule
